// ----- hdl/ttip_pkg.sv -----
// Package: item types, phase codes, character constants and helpers for the parser.
`timescale 1ns / 1ps
package ttip_pkg;

  localparam int unsigned ValueBits  = 32;
  localparam int unsigned OffsetBits = 12;
  localparam int unsigned BaseBits   = 6;
  localparam int unsigned CharBits   = 8;

  localparam logic [OffsetBits-1:0] MaxOffset   = OffsetBits'(4095);
  localparam logic [BaseBits-1:0]   BaseReset   = BaseBits'(10);
  localparam logic [BaseBits-1:0]   BaseDetect  = BaseBits'(0);
  localparam logic [BaseBits-1:0]   BaseOne     = BaseBits'(1);
  localparam logic [BaseBits-1:0]   BaseOctal   = BaseBits'(8);
  localparam logic [BaseBits-1:0]   BaseDecimal = BaseBits'(10);
  localparam logic [BaseBits-1:0]   BaseHex     = BaseBits'(16);
  localparam logic [BaseBits-1:0]   BaseMax     = BaseBits'(36);
  localparam logic [BaseBits-1:0]   NoDigit     = BaseBits'(63);

  localparam logic [CharBits-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharBits-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [CharBits-1:0] ChMinus = 8'h2d;  // '-'
  localparam logic [CharBits-1:0] ChPlus  = 8'h2b;  // '+'
  localparam logic [CharBits-1:0] ChLowX  = 8'h78;  // 'x'
  localparam logic [CharBits-1:0] ChUpX   = 8'h58;  // 'X'
  localparam logic [CharBits-1:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [CharBits-1:0] ChLowZ  = 8'h7a;  // 'z'
  localparam logic [CharBits-1:0] ChUpA   = 8'h41;  // 'A'
  localparam logic [CharBits-1:0] ChUpZ   = 8'h5a;  // 'Z'
  localparam logic [CharBits-1:0] ChSpace = 8'h20;
  localparam logic [CharBits-1:0] ChTab   = 8'h09;
  localparam logic [CharBits-1:0] ChCr    = 8'h0d;

  typedef enum logic [5:0] {
    PH_WS   = 6'b000001,
    PH_PFX  = 6'b000010,
    PH_ZERO = 6'b000100,
    PH_HEX1 = 6'b001000,
    PH_DIG  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [CharBits-1:0] char_code;
    logic                last_char;
  } in_item_t;

  typedef struct packed {
    logic [ValueBits-1:0]  parsed_value;
    logic [OffsetBits-1:0] end_offset;
  } out_item_t;

  // Value of a digit or letter, NoDigit for anything else.
  function automatic logic [BaseBits-1:0] digit_value(input logic [CharBits-1:0] c);
    logic [BaseBits-1:0] d;
    d = NoDigit;
    if (c >= ChZero && c <= ChNine) begin
      d = BaseBits'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowZ) begin
      d = BaseBits'(c - ChLowA) + BaseBits'(10);
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = BaseBits'(c - ChUpA) + BaseBits'(10);
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [CharBits-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

// ----- hdl/text_to_integer_parser_unit.sv -----
// Streaming text-to-integer parser: one character per transaction, one result per string.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) carries one text byte per
//   transaction; last_char marks the final byte of a string. Leading whitespace is
//   skipped, an optional sign and a 0x / 0X prefix are handled, then digits below the
//   base are accumulated modulo 2^32. The byte marked last produces one result on the
//   output channel (out_valid_o / out_ready_i / out_data_o): the value and the offset
//   just past the last converted digit, saturating at 4095.
//   The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the base
//   (0 detects it from the prefix); it is always ready and is sampled per string at the
//   first byte after whitespace and sign. Write it only while the block is idle.
//   Result: out_valid_o is registered and rises in the cycle after the last byte is accepted.
//   Throughput: one byte per cycle while the output is not stalled; each byte costs one
//   32x6 multiply-add in the accumulator update, which sets the cycle time.
//   Reset: base returns to 10, parsing restarts at whitespace skipping, no result pending.
//   Stall: a pending result holds in the output register; a new byte is still taken in
//   the same cycle the result is taken, so a receiver that keeps ready high sees no gap.
`timescale 1ns / 1ps
module text_to_integer_parser_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ttip_pkg::BaseBits-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ttip_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ttip_pkg::out_item_t               out_data_o
);
  import ttip_pkg::*;

  logic [BaseBits-1:0]   base_cfg_q;
  phase_e                phase_q, phase_d;
  logic [ValueBits-1:0]  acc_q, acc_d;
  logic                  minus_q, minus_d;
  logic [BaseBits-1:0]   abase_q, abase_d;
  logic [OffsetBits-1:0] cnt_q, cnt_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  logic                  in_fire;
  logic [CharBits-1:0]   c;
  logic [BaseBits-1:0]   dval;
  logic [OffsetBits-1:0] pos_inc;
  logic                  do_digit;
  logic [BaseBits-1:0]   dig_base;
  logic                  base_bad;
  logic [ValueBits-1:0]  acc_fin;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign c           = in_data_i.char_code;
  assign dval        = digit_value(c);
  assign pos_inc     = (pos_q < MaxOffset) ? pos_q + OffsetBits'(1) : pos_q;
  assign base_bad    = (base_cfg_q == BaseOne) || (base_cfg_q > BaseMax);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    minus_d  = minus_q;
    abase_d  = abase_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    do_digit = 1'b0;
    dig_base = abase_q;
    case (phase_q)
      PH_WS, PH_PFX: begin
        if (phase_q == PH_WS && is_space(c)) begin
          pos_d = pos_inc;
        end else if (phase_q == PH_WS && (c == ChMinus || c == ChPlus)) begin
          minus_d = (c == ChMinus);
          pos_d   = pos_inc;
          phase_d = PH_PFX;
        end else if (base_bad) begin
          phase_d = PH_DONE;
        end else if ((base_cfg_q == BaseDetect || base_cfg_q == BaseHex) && c == ChZero) begin
          abase_d = base_cfg_q;
          pos_d   = pos_inc;
          cnt_d   = pos_inc;
          phase_d = PH_ZERO;
        end else begin
          dig_base = (base_cfg_q == BaseDetect) ? BaseDecimal : base_cfg_q;
          abase_d  = dig_base;
          do_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (c == ChLowX || c == ChUpX) begin
          pos_d   = pos_inc;
          abase_d = BaseHex;
          phase_d = PH_HEX1;
        end else begin
          dig_base = (abase_q == BaseDetect) ? BaseOctal : BaseHex;
          abase_d  = dig_base;
          do_digit = 1'b1;
        end
      end
      PH_HEX1, PH_DIG: begin
        do_digit = 1'b1;
      end
      PH_DONE: begin
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
    if (do_digit) begin
      if (dval < dig_base) begin
        acc_d   = acc_q * ValueBits'(dig_base) + ValueBits'(dval);
        pos_d   = pos_inc;
        cnt_d   = pos_inc;
        phase_d = PH_DIG;
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  assign acc_fin = minus_d ? (ValueBits'(0) - acc_d) : acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_cfg_q  <= BaseReset;
      phase_q     <= PH_WS;
      acc_q       <= '0;
      minus_q     <= 1'b0;
      abase_q     <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        base_cfg_q <= cfg_data_i;
      end
      if (in_fire) begin
        if (in_data_i.last_char) begin
          // End of string: clear the parse state for the next one.
          phase_q <= PH_WS;
          acc_q   <= '0;
          minus_q <= 1'b0;
          abase_q <= '0;
          cnt_q   <= '0;
          pos_q   <= '0;
        end else begin
          phase_q <= phase_d;
          acc_q   <= acc_d;
          minus_q <= minus_d;
          abase_q <= abase_d;
          cnt_q   <= cnt_d;
          pos_q   <= pos_d;
        end
      end
      if (in_fire && in_data_i.last_char) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last_char) begin
      out_data_q.parsed_value <= acc_fin;
      out_data_q.end_offset   <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.last_char) |=>
      (phase_q == PH_WS && acc_q == '0 && cnt_q == '0 && out_valid_o))
    else $error("parse state not cleared or result missing after last character");

  a_ws_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WS) |-> (acc_q == '0 && cnt_q == '0 && !minus_q))
    else $error("accumulated state present while skipping whitespace");

  a_count_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pos_q)
    else $error("consumed count ahead of position");

  a_no_result_without_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(in_valid_i && in_ready_o && in_data_i.last_char)) |=> !out_valid_o)
    else $error("result raised without a last character");
`endif

endmodule

// ----- dv/parse_checker.sv -----
// Checker: watches the parser channels, predicts each parsed number and compares results.
`timescale 1ns / 1ps
module parse_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [ttip_pkg::BaseBits-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  ttip_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  ttip_pkg::out_item_t           out_data_o,
  output int                            open_count_o,
  output int                            error_count_o
);
  import ttip_pkg::*;

  localparam int NotADigit = 99;

  // Shadow of the base register and of the parse state
  logic [BaseBits-1:0]   base_reg;
  phase_e                phase;
  logic [ValueBits-1:0]  acc;
  logic                  minus;
  logic [BaseBits-1:0]   run_base;
  logic [OffsetBits-1:0] consumed;
  logic [OffsetBits-1:0] seen;

  out_item_t expected_numbers[$];
  int        errors;

  function automatic int char_digit(input logic [CharBits-1:0] c);
    if (c >= ChZero && c <= ChNine) return c - ChZero;
    if (c >= ChLowA && c <= ChLowZ) return c - ChLowA + 10;
    if (c >= ChUpA && c <= ChUpZ) return c - ChUpA + 10;
    return NotADigit;
  endfunction

  task automatic restart_string();
    phase    = PH_WS;
    acc      = '0;
    minus    = 1'b0;
    run_base = '0;
    consumed = '0;
    seen     = '0;
  endtask

  task automatic bump_position();
    if (seen < MaxOffset) seen = seen + 1'b1;
  endtask

  task automatic push_digit(input int d);
    acc = acc * ValueBits'(run_base) + ValueBits'(d);
    bump_position();
    consumed = seen;
  endtask

  task automatic parse_char(input logic [CharBits-1:0] c);
    int d;
    int r;
    bit done;
    done = 1'b0;
    if (phase == PH_WS) begin
      if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
        bump_position();
        done = 1'b1;
      end else if (c == ChMinus || c == ChPlus) begin
        minus = (c == ChMinus);
        bump_position();
        phase = PH_PFX;
        done = 1'b1;
      end else begin
        phase = PH_PFX;
      end
    end
    if (!done) begin
      if (phase == PH_PFX) begin
        // Sample the base once per string, here
        r = int'(base_reg);
        if (r == BaseOne || r > BaseMax) begin
          phase = PH_DONE;
          done = 1'b1;
        end else if ((r == BaseDetect || r == BaseHex) && c == ChZero) begin
          run_base = base_reg;
          bump_position();
          consumed = seen;
          phase = PH_ZERO;
          done = 1'b1;
        end else begin
          run_base = (r == BaseDetect) ? BaseDecimal : base_reg;
          phase = PH_DIG;
        end
      end else if (phase == PH_ZERO) begin
        if (c == ChLowX || c == ChUpX) begin
          bump_position();
          run_base = BaseHex;
          phase = PH_HEX1;
          done = 1'b1;
        end else begin
          run_base = (run_base == BaseDetect) ? BaseOctal : BaseHex;
          phase = PH_DIG;
        end
      end else if (phase == PH_HEX1) begin
        // A bare prefix keeps the offset at the zero
        d = char_digit(c);
        if (d < 16) begin
          push_digit(d);
          phase = PH_DIG;
        end else begin
          phase = PH_DONE;
        end
        done = 1'b1;
      end
    end
    if (!done && phase == PH_DIG) begin
      d = char_digit(c);
      if (d < int'(run_base)) push_digit(d);
      else phase = PH_DONE;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      base_reg = BaseReset;
      restart_string();
      expected_numbers.delete();
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) base_reg = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        parse_char(in_data_i.char_code);
        if (in_data_i.last_char) begin
          want.parsed_value = minus ? (~acc + 1'b1) : acc;
          want.end_offset   = consumed;
          expected_numbers.push_back(want);
          restart_string();
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_numbers.size() == 0) begin
          $error("unexpected result: parsed_value %0h end_offset %0d",
                 out_data_o.parsed_value, out_data_o.end_offset);
          errors++;
        end else begin
          want = expected_numbers.pop_front();
          if (out_data_o.parsed_value !== want.parsed_value) begin
            $error("parsed_value: expected %0h, actual %0h",
                   want.parsed_value, out_data_o.parsed_value);
            errors++;
          end
          if (out_data_o.end_offset !== want.end_offset) begin
            $error("end_offset: expected %0d, actual %0d",
                   want.end_offset, out_data_o.end_offset);
            errors++;
          end
        end
      end
    end
    open_count_o  = expected_numbers.size();
    error_count_o = errors;
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top: drives strings and base writes into the parser and reports the verdict.
`timescale 1ns / 1ps
module tb;
  import ttip_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [BaseBits-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;

  int open_count;
  int error_count;

  logic [CharBits-1:0] text_q[$];
  int  burst_left = 0;
  int  chars_sent = 0;
  bit  stress_on  = 1'b0;

  text_to_integer_parser_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  parse_checker u_parse_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .open_count_o  (open_count),
    .error_count_o (error_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("text_to_integer_parser_unit test failed");
    $finish;
  end

  // Receiver: segments of different stall patterns, with a long hold-off under stress
  initial begin
    int seg;
    int mode;
    int len;
    int cnt;
    bit held;
    seg  = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stress_on && (!held || seg % 15 == 0)) begin
        held = 1'b1;
        for (cnt = 0; cnt < 400; cnt++) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 150);
        for (cnt = 0; cnt < len; cnt++) begin
          @(negedge clk_i);
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= $urandom_range(0, 1);
            2: out_ready_i <= (cnt % 4 != 3);
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
      seg++;
    end
  end

  task automatic send_char(input logic [CharBits-1:0] c, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i           <= 1'b1;
    in_data_i.char_code  <= c;
    in_data_i.last_char  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Hold until every predicted result has come out, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (open_count != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [BaseBits-1:0] b);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CharBits-1:0] digit_char(input int d);
    if (d < 10) return ChZero + CharBits'(d);
    if ($urandom_range(0, 1) == 1) return ChUpA + CharBits'(d - 10);
    return ChLowA + CharBits'(d - 10);
  endfunction

  // Whitespace, sign, prefix, digits valid for the base, optional trailing text
  task automatic build_number(input logic [BaseBits-1:0] r);
    int b;
    int k;
    int nd;
    bit dec_lead;
    text_q.delete();
    dec_lead = 1'b0;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 1) == 1) text_q.push_back(ChSpace);
      else text_q.push_back(ChTab + CharBits'($urandom_range(0, 4)));
    end
    case ($urandom_range(0, 3))
      0: text_q.push_back(ChMinus);
      1: text_q.push_back(ChPlus);
      default: ;
    endcase
    b = int'(r);
    if (r == BaseDetect) begin
      case ($urandom_range(0, 2))
        0: begin
          b = 10;
          dec_lead = 1'b1;
        end
        1: begin
          b = 8;
          text_q.push_back(ChZero);
        end
        default: begin
          b = 16;
          text_q.push_back(ChZero);
          text_q.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
        end
      endcase
    end else if (r == BaseHex && $urandom_range(0, 1) == 1) begin
      text_q.push_back(ChZero);
      text_q.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
    end else if (r == BaseOne || r > BaseMax) begin
      b = 36;
    end
    nd = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
    for (k = 0; k < nd; k++) begin
      if (k == 0 && dec_lead) text_q.push_back(digit_char($urandom_range(1, 9)));
      else text_q.push_back(digit_char($urandom_range(0, b - 1)));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(CharBits'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic [BaseBits-1:0] b);
    int start;
    int sel;
    write_base(b);
    start = chars_sent;
    while (chars_sent - start < 70) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        text_q.delete();
        repeat ($urandom_range(1, 6)) text_q.push_back(CharBits'($urandom_range(0, 255)));
      end else begin
        build_number(b);
        if (sel == 1) begin
          // Cut the string short: bare prefix, lone sign, whitespace only
          while (text_q.size() > 1 && $urandom_range(0, 2) != 0) void'(text_q.pop_back());
        end else if (sel == 2) begin
          text_q[$urandom_range(0, text_q.size() - 1)] = CharBits'($urandom_range(0, 255));
        end
      end
      send_text();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings, reset base first
    add_str(" -42");  send_text();
    add_str("7x");    send_text();
    add_str("-");     send_text();
    add_str("\t");    send_text();
    text_q.push_back(8'hff);  send_text();
    add_str("9");  text_q.push_back(8'h00);  send_text();
    write_base(BaseHex);
    add_str("0x");    send_text();
    add_str("0XfF");  send_text();
    write_base(BaseDetect);
    add_str("017");   send_text();
    add_str("09");    send_text();
    write_base(BaseOne);
    add_str("5");     send_text();
    write_base(BaseMax);
    add_str("zZ");    send_text();

    stress_on = 1'b1;
    run_phase(BaseDetect);
    run_phase(BaseHex);
    run_phase(BaseOctal);
    run_phase(6'd2);
    run_phase(BaseMax);
    run_phase(BaseDecimal);
    run_phase(BaseOne);
    run_phase(6'd37);
    run_phase(6'd63);
    repeat (3) run_phase(BaseBits'($urandom_range(0, 63)));

    wait_drained();
    if (error_count == 0 && open_count == 0) begin
      $display("text_to_integer_parser_unit test passed");
    end else begin
      $display("text_to_integer_parser_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ttip_pkg.sv
hdl/text_to_integer_parser_unit.sv
dv/parse_checker.sv
dv/tb.sv
